[rtl/indexed_array_table_engine_macros.svh]
// Assertion macros used by the checker file of the table engine.
// No dependencies; include once per file that asserts.
`ifndef INDEXED_ARRAY_TABLE_ENGINE_MACROS_SVH
`define INDEXED_ARRAY_TABLE_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define IATE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("table engine check failed");

// Next-cycle implication, disabled while reset is low.
`define IATE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("table engine check failed");

`endif

[rtl/iate_pkg.sv]
// Shared types and constants of the indexed array table engine.
// No dependencies; every other file of the block but the macros header imports it.
package iate_pkg;

    localparam int DEPTH  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [2:0] OP_READ   = 3'd0;
    localparam logic [2:0] OP_SEARCH = 3'd1;
    localparam logic [2:0] OP_INSERT = 3'd2;
    localparam logic [2:0] OP_UPDATE = 3'd3;
    localparam logic [2:0] OP_DELETE = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [2:0]         func;
        logic [5:0]         position;
        logic signed [31:0] operand_value;
    } t_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         found_position;
        logic signed [31:0] read_data;
        logic [5:0]         fill_count;
    } t_res;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [31:0]       wr_data;
    } t_mem_req;

endpackage

[rtl/iate_store.sv]
// Entry storage of the table engine: one write port, one registered read port.
// Depends on iate_pkg for the depth and the request struct.
module iate_store (
    input  logic               i_clk,
    input  iate_pkg::t_mem_req i_req,
    output logic [31:0]        o_rd_data
);
    import iate_pkg::*;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    // Entries hold no reset value; only entries below the fill count are read.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/indexed_array_table_engine.sv]
// Read, search, insert and delete pass through a run state; update and rejected beats go straight
// to the finish state. Search, insert and delete walk the entries through the single read port,
// one per cycle. The worst case is a search that misses on a full table; a new beat is accepted
// only after the result is loaded into the output register.
// A finished result sits in the output register while the next beat is worked on.
// Synchronous active-low reset empties the table (fill count zero); no clearing pass.
module indexed_array_table_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    output logic            o_item_ready,
    input  iate_pkg::t_item i_item,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output iate_pkg::t_res  o_res
);
    import iate_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid, n_out_valid;
    logic              r_pend, n_pend;
    logic [2:0]        r_op, n_op;
    logic [5:0]        r_pos, n_pos;
    logic [31:0]       r_val, n_val;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [ADDR_W-1:0] r_pidx, n_pidx;
    logic [CNT_W-1:0]  r_left, n_left;
    t_res              r_pr, n_pr;
    t_res              r_out, n_out;
    t_mem_req          mem_req;
    logic [31:0]       rd_data;

    iate_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_res_ready;
        n_pend      = r_pend;
        n_op        = r_op;
        n_pos       = r_pos;
        n_val       = r_val;
        n_addr      = r_addr;
        n_pidx      = r_pidx;
        n_left      = r_left;
        n_pr        = r_pr;
        n_out       = r_out;
        mem_req     = '0;

        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_op   = i_item.func;
                    n_pos  = i_item.position;
                    n_val  = i_item.operand_value;
                    n_pend = 1'b0;
                    n_pr   = '{status: ST_RANGE, found_position: 5'd0,
                               read_data: 32'sd0, fill_count: r_count};
                    n_state = S_FIN;
                    case (i_item.func)
                        OP_READ: begin
                            if (i_item.position < r_count) begin
                                n_addr  = i_item.position[ADDR_W-1:0];
                                n_left  = CNT_W'(1);
                                n_state = S_RUN;
                            end
                        end
                        OP_SEARCH: begin
                            n_addr  = '0;
                            n_left  = r_count;
                            n_state = S_RUN;
                        end
                        OP_INSERT: begin
                            if (i_item.position > r_count) begin
                                n_pr.status = ST_RANGE;
                            end else if (r_count == CNT_W'(DEPTH)) begin
                                n_pr.status = ST_FULL;
                            end else begin
                                // Move entries from the top down so nothing is overwritten.
                                n_addr  = r_count[ADDR_W-1:0] - ADDR_W'(1);
                                n_left  = r_count - i_item.position;
                                n_state = S_RUN;
                            end
                        end
                        OP_UPDATE: begin
                            if (i_item.position < r_count) begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = i_item.position[ADDR_W-1:0];
                                mem_req.wr_data = i_item.operand_value;
                                n_pr.status     = ST_OK;
                            end
                        end
                        OP_DELETE: begin
                            if (i_item.position < r_count) begin
                                n_addr  = i_item.position[ADDR_W-1:0] + ADDR_W'(1);
                                n_left  = r_count - i_item.position - CNT_W'(1);
                                n_state = S_RUN;
                            end
                        end
                        default: begin
                            n_pr.status = ST_RANGE;
                        end
                    endcase
                end
            end

            S_RUN: begin
                // Issue one read a cycle; the data comes back on the following cycle.
                if (r_left != '0) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_addr;
                    n_pidx          = r_addr;
                    n_pend          = 1'b1;
                    n_left          = r_left - CNT_W'(1);
                    n_addr          = (r_op == OP_INSERT) ? r_addr - ADDR_W'(1)
                                                          : r_addr + ADDR_W'(1);
                end else begin
                    n_pend = 1'b0;
                end

                n_pr = '{status: ST_OK, found_position: 5'd0,
                         read_data: 32'sd0, fill_count: r_count};

                if (r_pend) begin
                    case (r_op)
                        OP_INSERT: begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = r_pidx + ADDR_W'(1);
                            mem_req.wr_data = rd_data;
                        end
                        OP_DELETE: begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = r_pidx - ADDR_W'(1);
                            mem_req.wr_data = rd_data;
                        end
                        OP_READ: begin
                            n_pr.read_data = signed'(rd_data);
                            n_state        = S_FIN;
                        end
                        OP_SEARCH: begin
                            if (rd_data == r_val) begin
                                n_pr.found_position = 5'(r_pidx);
                                n_state             = S_FIN;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end

                if (r_left == '0 && !r_pend) begin
                    n_state = S_FIN;
                    case (r_op)
                        OP_INSERT: begin
                            // All later entries have moved up; drop the new value in.
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = r_pos[ADDR_W-1:0];
                            mem_req.wr_data = r_val;
                            n_count         = r_count + CNT_W'(1);
                            n_pr.fill_count = r_count + CNT_W'(1);
                        end
                        OP_DELETE: begin
                            n_count         = r_count - CNT_W'(1);
                            n_pr.fill_count = r_count - CNT_W'(1);
                        end
                        OP_SEARCH: begin
                            n_pr.status = ST_NOT_FOUND;
                        end
                        default: begin
                            n_pr.status = ST_RANGE;
                        end
                    endcase
                end
            end

            S_FIN: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pr;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_pos  <= n_pos;
        r_val  <= n_val;
        r_addr <= n_addr;
        r_pidx <= n_pidx;
        r_left <= n_left;
        r_pr   <= n_pr;
        r_out  <= n_out;
    end

    assign o_item_ready = (r_state == S_IDLE);
    assign o_res_valid  = r_out_valid;
    assign o_res        = r_out;

endmodule

[rtl/iate_checker.sv]
// Port-level checks of the table engine, attached to the top level by bind.
// Depends on iate_pkg and the assertion macros header.
`include "indexed_array_table_engine_macros.svh"

module iate_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_item_valid,
    input logic            o_item_ready,
    input iate_pkg::t_item i_item,
    input logic            o_res_valid,
    input logic            i_res_ready,
    input iate_pkg::t_res  o_res
);
    import iate_pkg::*;

    // A stalled result beat must hold still.
    `IATE_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, o_res_valid && !i_res_ready, o_res_valid && $stable(o_res))

    // The sequencer is busy right after it takes a beat.
    `IATE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_item_valid && o_item_ready, !o_item_ready)

    `IATE_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_res_valid, o_res.fill_count <= 6'(DEPTH))

    // Failed operations report no index and no data.
    `IATE_ASSERT_NOW(a_fail_clean, i_clk, i_rst_n, o_res_valid && o_res.status != ST_OK, o_res.found_position == 5'd0 && o_res.read_data == 32'sd0)

endmodule

bind indexed_array_table_engine iate_checker u_iate_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_item_valid (i_item_valid),
    .o_item_ready (o_item_ready),
    .i_item       (i_item),
    .o_res_valid  (o_res_valid),
    .i_res_ready  (i_res_ready),
    .o_res        (o_res)
);

[tb/tb_indexed_array_table_engine.sv]
// Self-checking testbench for indexed_array_table_engine: read, search, insert,
// update and delete on the packed table, with randomized beat gaps and receiver stalls.
// Depends on iate_pkg and the engine RTL only.
`timescale 1ns / 100ps

module tb_indexed_array_table_engine;
    import iate_pkg::*;

    localparam int RANDOM_OPS     = 1500;
    localparam int MAX_GAP        = 10;
    localparam int HOLD_CYCLES    = 400;
    localparam int FIRST_HOLD_AT  = 300;
    localparam int SECOND_HOLD_AT = 1000;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = DEPTH + 8;
    localparam int MAX_REPORTS    = 10;

    localparam logic [2:0] FUNC_CODE_MAX   = 3'd7;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_MID   = 3'd6;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE} t_mix;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_item_valid = 1'b0;
    logic  o_item_ready;
    t_item item_beat = '0;
    logic  o_res_valid;
    logic  i_res_ready = 1'b0;
    t_res  res_beat;

    // Predictor state: a shadow of the table contents and fill count.
    logic signed [31:0] model_entries [DEPTH];
    int model_fill = 0;

    // Fill count as the stimulus generator expects it, used to aim positions.
    int plan_fill = 0;

    t_item op_backlog[$];
    t_res  table_results_due[$];

    int total_ops = 0;
    int ops_sent = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int op_tally [8];
    int status_tally [4];

    int send_gap = 0;
    bit send_rush = 1'b0;
    int take_stall = 0;
    bit take_rush = 1'b0;
    t_res due;
    t_res due_rx;

    indexed_array_table_engine uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item_valid),
        .o_item_ready (o_item_ready),
        .i_item       (item_beat),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_res        (res_beat)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_res apply_table_op(t_item op);
        t_res r;
        int pos;
        r = '0;
        pos = op.position;
        case (op.func)
            OP_READ: begin
                if (pos < model_fill) r.read_data = model_entries[pos];
                else r.status = ST_RANGE;
            end
            OP_SEARCH: begin
                // Walk downward so the lowest matching index wins.
                r.status = ST_NOT_FOUND;
                for (int i = model_fill - 1; i >= 0; i--) begin
                    if (model_entries[i] == op.operand_value) begin
                        r.status = ST_OK;
                        r.found_position = 5'(i);
                    end
                end
            end
            OP_INSERT: begin
                if (pos > model_fill) begin
                    r.status = ST_RANGE;
                end else if (model_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = model_fill; i > pos; i--)
                        model_entries[i] = model_entries[i - 1];
                    model_entries[pos] = op.operand_value;
                    model_fill++;
                end
            end
            OP_UPDATE: begin
                if (pos < model_fill) model_entries[pos] = op.operand_value;
                else r.status = ST_RANGE;
            end
            OP_DELETE: begin
                if (pos < model_fill) begin
                    for (int i = pos; i + 1 < model_fill; i++)
                        model_entries[i] = model_entries[i + 1];
                    model_fill--;
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default: r.status = ST_RANGE;
        endcase
        r.fill_count = 6'(model_fill);
        return r;
    endfunction

    task automatic queue_op(logic [2:0] func, int pos, logic signed [31:0] value);
        t_item op;
        op.func = func;
        op.position = 6'(pos);
        op.operand_value = value;
        op_backlog.push_back(op);
        if (func == OP_INSERT && pos <= plan_fill && plan_fill < DEPTH) plan_fill++;
        else if (func == OP_DELETE && pos < plan_fill) plan_fill--;
    endtask

    // Four draws in ten are small values so that searches and duplicates hit often.
    function automatic logic signed [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return VAL_MIN;
        if (roll == 1) return VAL_MAX;
        if (roll < 6) return $signed(32'($urandom_range(0, 7))) - 32'sd4;
        return $urandom();
    endfunction

    task automatic queue_random(t_mix mix);
        int roll;
        int pos;
        logic [2:0] func;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL: func = (roll < 60) ? OP_INSERT : (roll < 70) ? OP_SEARCH :
                             (roll < 80) ? OP_READ : (roll < 92) ? OP_UPDATE : OP_DELETE;
            MIX_DRAIN: func = (roll < 50) ? OP_DELETE : (roll < 65) ? OP_SEARCH :
                              (roll < 80) ? OP_READ : (roll < 92) ? OP_UPDATE : OP_INSERT;
            MIX_BALANCED: func = (roll < 20) ? OP_INSERT : (roll < 40) ? OP_SEARCH :
                                 (roll < 60) ? OP_READ : (roll < 80) ? OP_UPDATE : OP_DELETE;
            default: func = 3'($urandom_range(0, FUNC_CODE_MAX));
        endcase
        roll = $urandom_range(0, 99);
        if (mix == MIX_NOISE || roll < 2) begin
            pos = $urandom_range(0, 63);
        end else if (roll < 10) begin
            pos = plan_fill + $urandom_range(0, 1);
        end else if (func == OP_INSERT) begin
            pos = (roll < 55) ? plan_fill : $urandom_range(0, plan_fill);
        end else begin
            pos = (plan_fill > 0) ? $urandom_range(0, plan_fill - 1) : 0;
        end
        queue_op(func, pos, pick_value());
    endtask

    // Sender: offers queued operations with a random gap after each accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_item_valid <= 1'b0;
            model_fill = 0;
        end else begin
            if (i_item_valid && o_item_ready) begin
                due = apply_table_op(item_beat);
                table_results_due.push_back(due);
                status_tally[due.status]++;
                op_tally[item_beat.func]++;
                ops_sent++;
                if (ops_sent % 64 == 0) send_rush = ($urandom_range(0, 2) == 0);
                send_gap = send_rush ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (!(i_item_valid && !o_item_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_item_valid <= 1'b0;
                end else if (op_backlog.size() > 0) begin
                    item_beat <= op_backlog.pop_front();
                    i_item_valid <= 1'b1;
                end else begin
                    i_item_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result beat and stalls at random, with two long hold-offs.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
        end else begin
            if (o_res_valid && i_res_ready) begin
                results_seen++;
                if (table_results_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result beat %0d arrived with nothing pending: %p",
                                 results_seen, res_beat);
                end else begin
                    due_rx = table_results_due.pop_front();
                    if (res_beat.status !== due_rx.status ||
                        res_beat.found_position !== due_rx.found_position ||
                        res_beat.read_data !== due_rx.read_data ||
                        res_beat.fill_count !== due_rx.fill_count) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"result beat %0d: expected status %0d pos %0d data %h ",
                                      "fill %0d, got status %0d pos %0d data %h fill %0d"},
                                     results_seen, due_rx.status, due_rx.found_position,
                                     due_rx.read_data, due_rx.fill_count, res_beat.status,
                                     res_beat.found_position, res_beat.read_data,
                                     res_beat.fill_count);
                    end
                end
                if (results_seen % 64 == 0) take_rush = ($urandom_range(0, 2) == 0);
                take_stall = take_rush ? 0 : $urandom_range(0, MAX_GAP);
                if (results_seen == FIRST_HOLD_AT || results_seen == SECOND_HOLD_AT)
                    take_stall = HOLD_CYCLES;
            end
            if (take_stall > 0) begin
                take_stall--;
                i_res_ready <= 1'b0;
            end else begin
                i_res_ready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_item_valid && o_item_ready) || (o_res_valid && i_res_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("no beat moved for %0d cycles, stopping", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        t_mix mix;
        int seg_len;

        // Empty table: every index is out of range and searches miss.
        queue_op(OP_READ, 0, 32'sd0);
        queue_op(OP_SEARCH, 0, 32'sd0);
        queue_op(OP_UPDATE, 0, 32'sd5);
        queue_op(OP_DELETE, 0, 32'sd0);
        queue_op(OP_INSERT, 1, 32'sd7);
        // Build -1, 0, MIN, MAX by front, middle and end inserts.
        queue_op(OP_INSERT, 0, VAL_MIN);
        queue_op(OP_INSERT, 1, VAL_MAX);
        queue_op(OP_INSERT, 0, -32'sd1);
        queue_op(OP_INSERT, 1, 32'sd0);
        queue_op(OP_SEARCH, 0, VAL_MAX);
        // A duplicate makes the search return the lower index.
        queue_op(OP_UPDATE, 2, -32'sd1);
        queue_op(OP_SEARCH, 0, -32'sd1);
        queue_op(OP_READ, 3, 32'sd0);
        queue_op(OP_READ, 4, 32'sd0);
        queue_op(OP_READ, 63, 32'sd0);
        queue_op(OP_UPDATE, 4, 32'sd9);
        queue_op(OP_DELETE, 4, 32'sd0);
        queue_op(OP_DELETE, 0, 32'sd0);
        queue_op(OP_DELETE, 2, 32'sd0);
        queue_op(OP_SEARCH, 0, VAL_MIN);
        queue_op(OP_UNUSED_FIRST, 0, 32'sd0);
        queue_op(OP_UNUSED_MID, 0, 32'sd0);
        queue_op(OP_UNUSED_LAST, 0, 32'sd0);
        queue_op(OP_INSERT, 3, 32'sd1);

        total_ops = op_backlog.size() + RANDOM_OPS;
        while (op_backlog.size() < total_ops) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: mix = MIX_FILL;
                4, 5:       mix = MIX_DRAIN;
                6, 7, 8:    mix = MIX_BALANCED;
                default:    mix = MIX_NOISE;
            endcase
            seg_len = (mix == MIX_FILL) ? $urandom_range(40, 80) : $urandom_range(20, 60);
            while (seg_len > 0 && op_backlog.size() < total_ops) begin
                queue_random(mix);
                seg_len--;
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_sent < total_ops) @(posedge i_clk);
        while (table_results_due.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display({"Covered %0d operations: %0d read, %0d search, %0d insert, %0d update, ",
                  "%0d delete, %0d unused code; %0d results checked"},
                 ops_sent, op_tally[OP_READ], op_tally[OP_SEARCH], op_tally[OP_INSERT],
                 op_tally[OP_UPDATE], op_tally[OP_DELETE],
                 ops_sent - op_tally[OP_READ] - op_tally[OP_SEARCH] - op_tally[OP_INSERT]
                 - op_tally[OP_UPDATE] - op_tally[OP_DELETE], results_seen);
        $display({"Outcomes: %0d ok, %0d not found, %0d out of range, %0d table full; ",
                  "%0d mismatches"},
                 status_tally[ST_OK], status_tally[ST_NOT_FOUND], status_tally[ST_RANGE],
                 status_tally[ST_FULL], mismatch_count);
        if (mismatch_count == 0 && table_results_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
